// File: hw/rtl/pmlc_pkg.sv
`timescale 1ns / 1ps
// Package for the multiplexer link controller: shared types, codes and sizes.
// Used by every module of the block but pmlc_ram; depends on nothing.
package pmlc_pkg;

    // Receive FIFO size and the widths that follow from it.
    localparam int FIFO_DEPTH = 32;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Configuration port address width (seven registers at 4-byte spacing).
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // Status bytes seen by the host.
    localparam logic [7:0] STAT_EMPTY = 8'h14;
    localparam logic [7:0] STAT_DATA  = 8'h17;

    // Register indexes.
    typedef enum logic [2:0] {
        REG_LINK_EN     = 3'd0,
        REG_ESCAPE      = 3'd1,
        REG_SYNC        = 3'd2,
        REG_KBD_SEL     = 3'd3,
        REG_MOUSE_SEL   = 3'd4,
        REG_SESS_BEGIN  = 3'd5,
        REG_SESS_FINISH = 3'd6
    } reg_idx_t;

    // Reset values of the code registers.
    localparam logic [7:0] RST_ESCAPE      = 8'd125;
    localparam logic [7:0] RST_SYNC        = 8'd126;
    localparam logic [7:0] RST_KBD_SEL     = 8'd160;
    localparam logic [7:0] RST_MOUSE_SEL   = 8'd161;
    localparam logic [7:0] RST_SESS_BEGIN  = 8'd85;
    localparam logic [7:0] RST_SESS_FINISH = 8'd86;

    // Item operations.
    typedef enum logic [1:0] {
        OP_RX     = 2'd0,
        OP_STATUS = 2'd1,
        OP_READ   = 2'd2,
        OP_WRITE  = 2'd3
    } op_t;

    // Host write sequencer steps.
    typedef enum logic [2:0] {
        STEP_SEL  = 3'b001,
        STEP_ESC  = 3'b010,
        STEP_BYTE = 3'b100
    } tx_step_t;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic       link_en;
        logic [7:0] escape;
        logic [7:0] sync;
        logic [7:0] kbd_sel;
        logic [7:0] mouse_sel;
        logic [7:0] sess_begin;
        logic [7:0] sess_finish;
    } cfg_t;

    // One result word; read data itself comes from the FIFO RAM read register.
    typedef struct packed {
        logic       read_hit;
        logic [7:0] status_byte;
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       last;
        logic       byte_stored;
        logic       byte_lost;
        logic       overflow;
        logic       unexpected_sync;
    } res_t;

endpackage

// File: hw/rtl/ps2_mux_link_controller_core.sv
`timescale 1ns / 1ps
// Top level of the keyboard/mouse multiplexer link controller.
// Depends on pmlc_pkg, pmlc_cfg, pmlc_ctrl and pmlc_ram.
//
//   Channel   Direction  Ports                         Word
//   s_*       in         s_operation, s_data_in        one receive or host access
//   m_*       out        m_read_data ... m_last        one result / link byte
//   apb       in/out     psel penable pwrite paddr ... register access
//
// An accepted word is held in the input register; its result word goes to the
// output register. Receive, status and data read give one result per cycle back
// to back while m_ready is high; a host write holds the input register for one
// result word per link byte sent. A stalled m_ready holds the output register
// and, through it, the input register. Reset is synchronous, clears all control
// state and needs no clearing pass; FIFO bytes are not reset.
module ps2_mux_link_controller_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Input channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_operation,
    input  logic [7:0]                  s_data_in,
    // Result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_read_data,
    output logic [7:0]                  m_status_byte,
    output logic [7:0]                  m_tx_byte,
    output logic                        m_tx_valid,
    output logic                        m_last,
    output logic                        m_byte_stored,
    output logic                        m_byte_lost,
    output logic                        m_overflow,
    output logic                        m_unexpected_sync,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pmlc_pkg::APB_AW-1:0] paddr,
    input  logic [pmlc_pkg::APB_DW-1:0] pwdata,
    output logic [pmlc_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    pmlc_pkg::cfg_t             cfg;
    pmlc_pkg::res_t             res_next;
    pmlc_pkg::res_t             res_reg;
    logic                       res_valid_reg;
    logic                       in_valid_reg;
    pmlc_pkg::op_t              in_op_reg;
    logic [7:0]                 in_data_reg;
    logic                       advance;
    logic                       item_done;
    logic                       ram_wr_en;
    logic [pmlc_pkg::PTR_W-1:0] ram_wr_addr;
    logic [7:0]                 ram_wr_data;
    logic                       ram_rd_en;
    logic [pmlc_pkg::PTR_W-1:0] ram_rd_addr;
    logic [7:0]                 ram_rd_data;

    // The output register takes a new word when empty or being drained.
    assign advance = !res_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || (item_done && advance);

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg   <= pmlc_pkg::op_t'(s_operation);
            in_data_reg <= s_data_in;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (advance) begin
            res_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            res_reg <= res_next;
        end
    end

    pmlc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pmlc_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .item_valid  (in_valid_reg),
        .item_op     (in_op_reg),
        .item_data   (in_data_reg),
        .advance     (advance),
        .res         (res_next),
        .item_done   (item_done),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr)
    );

    pmlc_ram #(
        .DEPTH (pmlc_pkg::FIFO_DEPTH),
        .WIDTH (8)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // The RAM read register lines up with the output register of a data read.
    assign m_valid           = res_valid_reg;
    assign m_read_data       = res_reg.read_hit ? ram_rd_data : 8'd0;
    assign m_status_byte     = res_reg.status_byte;
    assign m_tx_byte         = res_reg.tx_byte;
    assign m_tx_valid        = res_reg.tx_valid;
    assign m_last            = res_reg.last;
    assign m_byte_stored     = res_reg.byte_stored;
    assign m_byte_lost       = res_reg.byte_lost;
    assign m_overflow        = res_reg.overflow;
    assign m_unexpected_sync = res_reg.unexpected_sync;

endmodule

// File: hw/rtl/pmlc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Holds the receive FIFO bytes; no package dependency.
module pmlc_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data register holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/pmlc_cfg.sv
`timescale 1ns / 1ps
// APB-style configuration registers: link enable and the six link codes.
// Depends on pmlc_pkg.
module pmlc_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pmlc_pkg::APB_AW-1:0] paddr,
    input  logic [pmlc_pkg::APB_DW-1:0] pwdata,
    output logic [pmlc_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output pmlc_pkg::cfg_t              cfg
);

    pmlc_pkg::cfg_t     cfg_reg;
    pmlc_pkg::reg_idx_t idx;
    logic               wr_fire;

    assign idx     = pmlc_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_fire = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register writes on the access phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.link_en     <= 1'b0;
            cfg_reg.escape      <= pmlc_pkg::RST_ESCAPE;
            cfg_reg.sync        <= pmlc_pkg::RST_SYNC;
            cfg_reg.kbd_sel     <= pmlc_pkg::RST_KBD_SEL;
            cfg_reg.mouse_sel   <= pmlc_pkg::RST_MOUSE_SEL;
            cfg_reg.sess_begin  <= pmlc_pkg::RST_SESS_BEGIN;
            cfg_reg.sess_finish <= pmlc_pkg::RST_SESS_FINISH;
        end else if (wr_fire) begin
            unique case (idx)
                pmlc_pkg::REG_LINK_EN:     cfg_reg.link_en     <= pwdata[0];
                pmlc_pkg::REG_ESCAPE:      cfg_reg.escape      <= pwdata[7:0];
                pmlc_pkg::REG_SYNC:        cfg_reg.sync        <= pwdata[7:0];
                pmlc_pkg::REG_KBD_SEL:     cfg_reg.kbd_sel     <= pwdata[7:0];
                pmlc_pkg::REG_MOUSE_SEL:   cfg_reg.mouse_sel   <= pwdata[7:0];
                pmlc_pkg::REG_SESS_BEGIN:  cfg_reg.sess_begin  <= pwdata[7:0];
                pmlc_pkg::REG_SESS_FINISH: cfg_reg.sess_finish <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read mux.
    always_comb begin
        prdata = '0;
        unique case (idx)
            pmlc_pkg::REG_LINK_EN:     prdata[0]   = cfg_reg.link_en;
            pmlc_pkg::REG_ESCAPE:      prdata[7:0] = cfg_reg.escape;
            pmlc_pkg::REG_SYNC:        prdata[7:0] = cfg_reg.sync;
            pmlc_pkg::REG_KBD_SEL:     prdata[7:0] = cfg_reg.kbd_sel;
            pmlc_pkg::REG_MOUSE_SEL:   prdata[7:0] = cfg_reg.mouse_sel;
            pmlc_pkg::REG_SESS_BEGIN:  prdata[7:0] = cfg_reg.sess_begin;
            pmlc_pkg::REG_SESS_FINISH: prdata[7:0] = cfg_reg.sess_finish;
            default:                   prdata      = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/pmlc_ctrl.sv
`timescale 1ns / 1ps
// Link state, FIFO pointers and the per-word result logic of the controller.
// Depends on pmlc_pkg; drives the FIFO RAM ports.
module pmlc_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  pmlc_pkg::cfg_t             cfg,
    input  logic                       item_valid,
    input  pmlc_pkg::op_t              item_op,
    input  logic [7:0]                 item_data,
    input  logic                       advance,
    output pmlc_pkg::res_t             res,
    output logic                       item_done,
    output logic                       ram_wr_en,
    output logic [pmlc_pkg::PTR_W-1:0] ram_wr_addr,
    output logic [7:0]                 ram_wr_data,
    output logic                       ram_rd_en,
    output logic [pmlc_pkg::PTR_W-1:0] ram_rd_addr
);

    localparam logic [pmlc_pkg::PTR_W-1:0] LAST_IDX =
        pmlc_pkg::PTR_W'(pmlc_pkg::FIFO_DEPTH - 1);
    localparam logic [pmlc_pkg::CNT_W-1:0] FULL_CNT =
        pmlc_pkg::CNT_W'(pmlc_pkg::FIFO_DEPTH);

    logic [pmlc_pkg::CNT_W-1:0] count_reg, count_next;
    logic [pmlc_pkg::PTR_W-1:0] wr_idx_reg, wr_idx_next;
    logic [pmlc_pkg::PTR_W-1:0] rd_idx_reg, rd_idx_next;
    logic                       esc_pend_reg, esc_pend_next;
    logic                       sync_reg, sync_next;
    logic                       mouse_reg, mouse_next;
    logic                       cmd_pend_reg, cmd_pend_next;
    pmlc_pkg::tx_step_t         step_reg, step_next;

    logic fire;
    logic deliver;
    logic push;
    logic pop;
    logic is_code;
    logic not_empty;

    assign fire      = item_valid && advance;
    assign not_empty = (count_reg != '0);
    assign is_code   = (item_data == cfg.escape) || (item_data == cfg.sync) ||
                       (item_data == cfg.kbd_sel) || (item_data == cfg.mouse_sel) ||
                       (item_data == cfg.sess_begin) || (item_data == cfg.sess_finish);

    // Result word and next state for the item in the input register.
    always_comb begin
        res           = '0;
        esc_pend_next = esc_pend_reg;
        sync_next     = sync_reg;
        mouse_next    = mouse_reg;
        cmd_pend_next = cmd_pend_reg;
        step_next     = step_reg;
        deliver       = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        item_done     = item_valid;

        unique case (item_op)
            pmlc_pkg::OP_RX: begin
                res.last = 1'b1;
                if (cfg.link_en) begin
                    // Deframing in priority order: escape, sync, selectors, session.
                    if (esc_pend_reg) begin
                        esc_pend_next = 1'b0;
                        deliver       = 1'b1;
                    end else if (item_data == cfg.escape) begin
                        esc_pend_next = 1'b1;
                    end else if (item_data == cfg.sync) begin
                        sync_next = 1'b1;
                    end else if (item_data == cfg.kbd_sel) begin
                        mouse_next = 1'b0;
                    end else if (item_data == cfg.mouse_sel) begin
                        mouse_next = 1'b1;
                    end else if (item_data == cfg.sess_begin ||
                                 item_data == cfg.sess_finish) begin
                        deliver = 1'b0;
                    end else begin
                        deliver = 1'b1;
                    end
                end

                // Delivery of a data byte on the selected channel.
                if (deliver) begin
                    if (mouse_reg) begin
                        res.byte_lost = 1'b1;
                    end else if (cmd_pend_reg && !sync_reg) begin
                        res.byte_lost = 1'b1;
                    end else begin
                        if (cmd_pend_reg) begin
                            cmd_pend_next = 1'b0;
                            sync_next     = 1'b0;
                        end
                        if (count_reg < FULL_CNT) begin
                            push            = 1'b1;
                            res.byte_stored = 1'b1;
                        end else begin
                            res.overflow = 1'b1;
                        end
                        // A sync left over without a pending command.
                        if (sync_reg && !cmd_pend_reg) begin
                            sync_next           = 1'b0;
                            res.unexpected_sync = 1'b1;
                        end
                    end
                end
            end
            pmlc_pkg::OP_STATUS: begin
                res.last        = 1'b1;
                res.status_byte = not_empty ? pmlc_pkg::STAT_DATA : pmlc_pkg::STAT_EMPTY;
            end
            pmlc_pkg::OP_READ: begin
                res.last     = 1'b1;
                res.read_hit = not_empty;
                pop          = not_empty;
            end
            pmlc_pkg::OP_WRITE: begin
                // Selector, optional escape, then the byte itself.
                res.tx_valid = 1'b1;
                unique case (step_reg)
                    pmlc_pkg::STEP_SEL: begin
                        res.tx_byte   = cfg.kbd_sel;
                        cmd_pend_next = 1'b1;
                        step_next     = is_code ? pmlc_pkg::STEP_ESC : pmlc_pkg::STEP_BYTE;
                        item_done     = 1'b0;
                    end
                    pmlc_pkg::STEP_ESC: begin
                        res.tx_byte = cfg.escape;
                        step_next   = pmlc_pkg::STEP_BYTE;
                        item_done   = 1'b0;
                    end
                    pmlc_pkg::STEP_BYTE: begin
                        res.tx_byte = item_data;
                        res.last    = 1'b1;
                        step_next   = pmlc_pkg::STEP_SEL;
                    end
                    default: begin
                        step_next = pmlc_pkg::STEP_SEL;
                        item_done = 1'b0;
                    end
                endcase
            end
            default: res = '0;
        endcase
    end

    // FIFO pointer and count updates; at most one of push and pop per word.
    always_comb begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        count_next  = count_reg;
        if (push) begin
            wr_idx_next = (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end else if (pop) begin
            rd_idx_next = (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
    end

    assign ram_wr_en   = fire && push;
    assign ram_wr_addr = wr_idx_reg;
    assign ram_wr_data = item_data;
    assign ram_rd_en   = fire && pop;
    assign ram_rd_addr = rd_idx_reg;

    // State registers advance once per result word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            wr_idx_reg   <= '0;
            rd_idx_reg   <= '0;
            esc_pend_reg <= 1'b0;
            sync_reg     <= 1'b0;
            mouse_reg    <= 1'b0;
            cmd_pend_reg <= 1'b0;
            step_reg     <= pmlc_pkg::STEP_SEL;
        end else if (fire) begin
            count_reg    <= count_next;
            wr_idx_reg   <= wr_idx_next;
            rd_idx_reg   <= rd_idx_next;
            esc_pend_reg <= esc_pend_next;
            sync_reg     <= sync_next;
            mouse_reg    <= mouse_next;
            cmd_pend_reg <= cmd_pend_next;
            step_reg     <= step_next;
        end
    end

endmodule
